// ===== sv/line_rect_clipper_unit_assert.svh =====
// Assertion macros shared by the line rectangle clipper RTL
`ifndef LINE_RECT_CLIPPER_UNIT_ASSERT_SVH
`define LINE_RECT_CLIPPER_UNIT_ASSERT_SVH
`ifndef SYNTH
`define LRC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("line_rect_clipper assertion failed");
`define LRC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("line_rect_clipper assertion failed");
`else
`define LRC_ASSERT_IMP(lbl, ante, cons)
`define LRC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== sv/lrc_pkg.sv =====
// Types, constants and codes shared by the line rectangle clipper
`timescale 1ns / 1ps
`default_nettype none
package lrc_pkg;
	localparam int CW     = 24;       // coordinate bits, signed Q16.8
	localparam int PF     = 16;       // parameter fraction bits
	localparam int NQ     = PF + 1;   // quotient bits from the divider
	localparam int LW     = PF + 3;   // signed parameter, minus one lsb .. one plus one lsb
	localparam int DW     = CW + 1;   // coordinate difference
	localparam int RW     = CW + 2;   // divider remainder
	localparam int PW     = LW + DW;  // parameter times delta
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	typedef logic signed [CW-1:0] coord_t;
	typedef logic signed [DW-1:0] delta_t;
	typedef logic [DW-1:0]        mag_t;
	typedef logic [RW-1:0]        rem_t;
	typedef logic [NQ-1:0]        quot_t;
	typedef logic signed [LW-1:0] lam_t;
	typedef logic signed [PW-1:0] prod_t;
	typedef logic [2:0]           side_t;

	localparam side_t SIDE_TOP    = 3'd0;
	localparam side_t SIDE_LEFT   = 3'd1;
	localparam side_t SIDE_BOTTOM = 3'd2;
	localparam side_t SIDE_RIGHT  = 3'd3;
	localparam side_t SIDE_NONE   = 3'd4;

	// outcode bit order: left, right, bottom, top
	localparam side_t SIDE_OF_BIT [4] = '{SIDE_LEFT, SIDE_RIGHT, SIDE_BOTTOM, SIDE_TOP};

	typedef enum logic [1:0] {
		REG_LEFT   = 2'd0,
		REG_RIGHT  = 2'd1,
		REG_BOTTOM = 2'd2,
		REG_TOP    = 2'd3
	} cfg_idx_t;

	localparam coord_t LEFT_RST   = coord_t'(0);
	localparam coord_t RIGHT_RST  = coord_t'(163840);
	localparam coord_t BOTTOM_RST = coord_t'(0);
	localparam coord_t TOP_RST    = coord_t'(122880);

	localparam lam_t  LAM_ZERO  = lam_t'(0);
	localparam lam_t  LAM_ONE   = lam_t'(2 ** PF);
	localparam lam_t  LAM_SAT   = lam_t'(2 ** PF + 1);
	localparam lam_t  LAM_NEG   = lam_t'(-1);
	localparam quot_t QUOT_ONE  = quot_t'(2 ** PF);

	typedef struct packed {
		logic       reject;
		coord_t     sx;
		coord_t     sy;
		delta_t     dx;
		delta_t     dy;
		logic [3:0] os;
		logic [3:0] ot;
		logic [3:0] skip;   // bound plays no part
		logic [3:0] zden;   // zero delta on the bound's axis
		logic [3:0] neg;    // quotient sign
	} lrc_ctl_t;

	typedef struct packed {
		lrc_ctl_t   ctl;
		mag_t [3:0] an;
		mag_t [3:0] ad;
	} lrc_job_t;
endpackage
`default_nettype wire

// ===== sv/lrc_front.sv =====
// Front end: clip registers, outcodes and per-bound distances
`timescale 1ns / 1ps
`default_nettype none
module lrc_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_stall,
	input  wire lrc_pkg::coord_t start_x,
	input  wire lrc_pkg::coord_t start_y,
	input  wire lrc_pkg::coord_t end_x,
	input  wire lrc_pkg::coord_t end_y,
	input  wire logic            cfg_we,
	input  wire logic [1:0]      cfg_index,
	input  wire lrc_pkg::coord_t cfg_data,
	input  wire logic            q_full,
	output logic                 q_wr,
	output lrc_pkg::lrc_job_t    q_job
);
	import lrc_pkg::*;

	coord_t left_q, right_q, bottom_q, top_q;
	coord_t bnd [4];
	delta_t num [4];
	delta_t dx, dy;
	mag_t   adx, ady;
	logic   [3:0] os, ot;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= LEFT_RST;
			right_q  <= RIGHT_RST;
			bottom_q <= BOTTOM_RST;
			top_q    <= TOP_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				REG_LEFT:   left_q   <= cfg_data;
				REG_RIGHT:  right_q  <= cfg_data;
				REG_BOTTOM: bottom_q <= cfg_data;
				REG_TOP:    top_q    <= cfg_data;
				default:    left_q   <= left_q;
			endcase
		end
	end

	always_comb begin
		bnd[0] = left_q;
		bnd[1] = right_q;
		bnd[2] = bottom_q;
		bnd[3] = top_q;

		os[0] = start_x < left_q;
		os[1] = !os[0] && (start_x > right_q);
		os[2] = start_y < bottom_q;
		os[3] = !os[2] && (start_y > top_q);
		ot[0] = end_x < left_q;
		ot[1] = !ot[0] && (end_x > right_q);
		ot[2] = end_y < bottom_q;
		ot[3] = !ot[2] && (end_y > top_q);

		dx  = delta_t'(end_x) - delta_t'(start_x);
		dy  = delta_t'(end_y) - delta_t'(start_y);
		adx = dx[DW-1] ? mag_t'(-dx) : mag_t'(dx);
		ady = dy[DW-1] ? mag_t'(-dy) : mag_t'(dy);

		q_job.ctl.reject = |(os & ot);
		q_job.ctl.sx     = start_x;
		q_job.ctl.sy     = start_y;
		q_job.ctl.dx     = dx;
		q_job.ctl.dy     = dy;
		q_job.ctl.os     = os;
		q_job.ctl.ot     = ot;
		for (int k = 0; k < 4; k++) begin
			num[k] = delta_t'(bnd[k]) - ((k < 2) ? delta_t'(start_x) : delta_t'(start_y));
			q_job.an[k] = num[k][DW-1] ? mag_t'(-num[k]) : mag_t'(num[k]);
			q_job.ad[k] = (k < 2) ? adx : ady;
			q_job.ctl.zden[k] = (k < 2) ? (dx == '0) : (dy == '0);
			q_job.ctl.neg[k]  = num[k][DW-1] != ((k < 2) ? dx[DW-1] : dy[DW-1]);
			q_job.ctl.skip[k] = !(os[k] || ot[k]) || ((num[k] == '0) && q_job.ctl.zden[k]);
		end
	end

	assign in_stall = q_full;
	assign q_wr     = in_valid && !q_full;
endmodule
`default_nettype wire

// ===== sv/lrc_queue.sv =====
// Short item queue between the front end and the clipping pipeline
`timescale 1ns / 1ps
`default_nettype none
`include "line_rect_clipper_unit_assert.svh"
module lrc_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr,
	input  wire lrc_pkg::lrc_job_t wr_job,
	output logic                   full,
	input  wire logic              pop,
	output logic                   empty,
	output lrc_pkg::lrc_job_t      head
);
	import lrc_pkg::*;

	lrc_job_t       mem_q [QDEPTH];
	logic [QAW-1:0] wp_q, rp_q;
	logic [QAW:0]   cnt_q;

	assign full  = cnt_q == (QAW+1)'(QDEPTH);
	assign empty = cnt_q == '0;
	assign head  = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			if (wr && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !wr) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_job;
	end

	`LRC_ASSERT_IMP(a_no_write_full, full, !wr)
	`LRC_ASSERT_IMP(a_no_pop_empty, empty, !pop)
	`LRC_ASSERT_IMP(a_count_bound, 1'b1, cnt_q <= (QAW+1)'(QDEPTH))
endmodule
`default_nettype wire

// ===== sv/lrc_back.sv =====
// Back end: pipelined dividers, parameter selection, scaling and output register
`timescale 1ns / 1ps
`default_nettype none
`include "line_rect_clipper_unit_assert.svh"
module lrc_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              q_empty,
	input  wire lrc_pkg::lrc_job_t q_head,
	output logic                   q_pop,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic                   hit,
	output lrc_pkg::coord_t        clipped_start_x,
	output lrc_pkg::coord_t        clipped_start_y,
	output lrc_pkg::coord_t        clipped_end_x,
	output lrc_pkg::coord_t        clipped_end_y,
	output lrc_pkg::side_t         entry_side,
	output lrc_pkg::side_t         exit_side
);
	import lrc_pkg::*;

	logic adv;

	// divider stages, one quotient bit per stage
	logic [NQ:1] div_v_s;
	lrc_ctl_t    div_ctl_s [NQ:1];
	rem_t        div_rem_s [NQ:1][4];
	mag_t        div_ad_s  [NQ:1][4];
	quot_t       div_q_s   [NQ:1][4];
	logic        div_big_s [NQ:1][4];
	rem_t        rem_n     [NQ:1][4];
	quot_t       q_n       [NQ:1][4];
	rem_t        r2;
	logic        ge;

	// selection
	lam_t  lam [4];
	lam_t  ent, lv;
	side_t es, xs;
	logic  sel_hit;
	logic  res_v_s1, res_hit_s1;
	lam_t  res_ent_s1, res_lv_s1;
	side_t res_es_s1, res_xs_s1;
	coord_t res_sx_s1, res_sy_s1;
	delta_t res_dx_s1, res_dy_s1;

	// products
	logic   mul_v_s2, mul_hit_s2;
	side_t  mul_es_s2, mul_xs_s2;
	coord_t mul_sx_s2, mul_sy_s2;
	prod_t  mul_p_s2 [4];

	logic   out_valid_q, hit_q;
	coord_t csx_q, csy_q, cex_q, cey_q;
	side_t  es_q, xs_q;

	assign adv   = !out_valid_q || !out_stall;
	assign q_pop = adv && !q_empty;

	always_comb begin
		for (int l = 0; l < 4; l++) begin
			r2 = rem_t'(q_head.an[l]);
			ge = r2 >= rem_t'(q_head.ad[l]);
			rem_n[1][l] = ge ? r2 - rem_t'(q_head.ad[l]) : r2;
			q_n[1][l]   = quot_t'(ge);
		end
		for (int j = 2; j <= NQ; j++) begin
			for (int l = 0; l < 4; l++) begin
				r2 = div_rem_s[j-1][l] << 1;
				ge = r2 >= rem_t'(div_ad_s[j-1][l]);
				rem_n[j][l] = ge ? r2 - rem_t'(div_ad_s[j-1][l]) : r2;
				q_n[j][l]   = {div_q_s[j-1][l][NQ-2:0], ge};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_v_s     <= '0;
			res_v_s1    <= 1'b0;
			mul_v_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			div_v_s     <= {div_v_s[NQ-1:1], q_pop};
			res_v_s1    <= div_v_s[NQ];
			mul_v_s2    <= res_v_s1;
			out_valid_q <= mul_v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			div_ctl_s[1] <= q_head.ctl;
			for (int l = 0; l < 4; l++) begin
				div_rem_s[1][l] <= rem_n[1][l];
				div_q_s[1][l]   <= q_n[1][l];
				div_ad_s[1][l]  <= q_head.ad[l];
				div_big_s[1][l] <= rem_t'(q_head.an[l]) >= (rem_t'(q_head.ad[l]) << 1);
			end
			for (int j = 2; j <= NQ; j++) begin
				div_ctl_s[j] <= div_ctl_s[j-1];
				for (int l = 0; l < 4; l++) begin
					div_rem_s[j][l] <= rem_n[j][l];
					div_q_s[j][l]   <= q_n[j][l];
					div_ad_s[j][l]  <= div_ad_s[j-1][l];
					div_big_s[j][l] <= div_big_s[j-1][l];
				end
			end
		end
	end

	// saturate quotients, then pick entry and exit in bound order
	always_comb begin
		for (int l = 0; l < 4; l++) begin
			if (div_ctl_s[NQ].zden[l])
				lam[l] = div_ctl_s[NQ].neg[l] ? LAM_NEG : LAM_SAT;
			else if (div_ctl_s[NQ].neg[l])
				lam[l] = (!div_big_s[NQ][l] && div_q_s[NQ][l] == '0) ? LAM_ZERO : LAM_NEG;
			else if (div_big_s[NQ][l] || div_q_s[NQ][l] > QUOT_ONE)
				lam[l] = LAM_SAT;
			else
				lam[l] = lam_t'({1'b0, div_q_s[NQ][l]});
		end
		ent = LAM_ZERO;
		lv  = LAM_ONE;
		es  = SIDE_NONE;
		xs  = SIDE_NONE;
		for (int k = 0; k < 4; k++) begin
			if (!div_ctl_s[NQ].skip[k]) begin
				if (div_ctl_s[NQ].os[k] && lam[k] > ent) begin
					ent = lam[k];
					es  = SIDE_OF_BIT[k];
				end
				if (div_ctl_s[NQ].ot[k] && lam[k] < lv) begin
					lv = lam[k];
					xs = SIDE_OF_BIT[k];
				end
			end
		end
		sel_hit = !div_ctl_s[NQ].reject && !(ent > lv);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_hit_s1 <= sel_hit;
			res_ent_s1 <= ent;
			res_lv_s1  <= lv;
			res_es_s1  <= sel_hit ? es : SIDE_NONE;
			res_xs_s1  <= sel_hit ? xs : SIDE_NONE;
			res_sx_s1  <= div_ctl_s[NQ].sx;
			res_sy_s1  <= div_ctl_s[NQ].sy;
			res_dx_s1  <= div_ctl_s[NQ].dx;
			res_dy_s1  <= div_ctl_s[NQ].dy;

			mul_hit_s2  <= res_hit_s1;
			mul_es_s2   <= res_es_s1;
			mul_xs_s2   <= res_xs_s1;
			mul_sx_s2   <= res_sx_s1;
			mul_sy_s2   <= res_sy_s1;
			mul_p_s2[0] <= prod_t'(res_ent_s1) * prod_t'(res_dx_s1);
			mul_p_s2[1] <= prod_t'(res_ent_s1) * prod_t'(res_dy_s1);
			mul_p_s2[2] <= prod_t'(res_lv_s1) * prod_t'(res_dx_s1);
			mul_p_s2[3] <= prod_t'(res_lv_s1) * prod_t'(res_dy_s1);

			hit_q <= mul_hit_s2;
			es_q  <= mul_es_s2;
			xs_q  <= mul_xs_s2;
			// arithmetic shift gives the floor of param times delta
			csx_q <= mul_hit_s2 ? coord_t'(prod_t'(mul_sx_s2) + (mul_p_s2[0] >>> PF)) : '0;
			csy_q <= mul_hit_s2 ? coord_t'(prod_t'(mul_sy_s2) + (mul_p_s2[1] >>> PF)) : '0;
			cex_q <= mul_hit_s2 ? coord_t'(prod_t'(mul_sx_s2) + (mul_p_s2[2] >>> PF)) : '0;
			cey_q <= mul_hit_s2 ? coord_t'(prod_t'(mul_sy_s2) + (mul_p_s2[3] >>> PF)) : '0;
		end
	end

	assign out_valid       = out_valid_q;
	assign hit             = hit_q;
	assign clipped_start_x = csx_q;
	assign clipped_start_y = csy_q;
	assign clipped_end_x   = cex_q;
	assign clipped_end_y   = cey_q;
	assign entry_side      = es_q;
	assign exit_side       = xs_q;

	`LRC_ASSERT_IMP(a_miss_sides, out_valid_q && !hit_q, es_q == SIDE_NONE && xs_q == SIDE_NONE)
	`LRC_ASSERT_IMP(a_miss_zero, out_valid_q && !hit_q, csx_q == '0 && cey_q == '0)
	`LRC_ASSERT_NXT(a_pop_enters, q_pop, div_v_s[1])
endmodule
`default_nettype wire

// ===== sv/line_rect_clipper_unit.sv =====
// Top level of the line rectangle clipper: front end, item queue, clipping pipeline
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+---------------------------------------
//  in      | input     | in_valid / in_stall      | start_x start_y end_x end_y
//  out     | output    | out_valid / out_stall    | hit clipped_* entry_side exit_side
//  cfg     | input     | cfg_we                   | cfg_index cfg_data
//
//  One item per cycle sustained while out_stall is low; the restoring divider is pipelined,
//  one quotient bit per stage.
//  arst_n clears the clip registers to their defaults and all valid flags.
//  out_stall freezes the pipeline while out_valid is high; the four-entry queue keeps
//  taking items until full, and in_stall is raised only when it is.
`timescale 1ns / 1ps
`default_nettype none
module line_rect_clipper_unit (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_stall,
	input  wire lrc_pkg::coord_t start_x,
	input  wire lrc_pkg::coord_t start_y,
	input  wire lrc_pkg::coord_t end_x,
	input  wire lrc_pkg::coord_t end_y,
	output logic                 out_valid,
	input  wire logic            out_stall,
	output logic                 hit,
	output lrc_pkg::coord_t      clipped_start_x,
	output lrc_pkg::coord_t      clipped_start_y,
	output lrc_pkg::coord_t      clipped_end_x,
	output lrc_pkg::coord_t      clipped_end_y,
	output lrc_pkg::side_t       entry_side,
	output lrc_pkg::side_t       exit_side,
	input  wire logic            cfg_we,
	input  wire logic [1:0]      cfg_index,
	input  wire lrc_pkg::coord_t cfg_data
);
	import lrc_pkg::*;

	logic     q_full, q_wr, q_empty, q_pop;
	lrc_job_t q_job, q_head;

	// classify: outcodes, trivial reject, bound distances and deltas
	lrc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.start_x   (start_x),
		.start_y   (start_y),
		.end_x     (end_x),
		.end_y     (end_y),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_full    (q_full),
		.q_wr      (q_wr),
		.q_job     (q_job)
	);

	// decouples input acceptance from output backpressure
	lrc_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.wr_job (q_job),
		.full   (q_full),
		.pop    (q_pop),
		.empty  (q_empty),
		.head   (q_head)
	);

	// four parallel dividers, entry/exit pick, scale and add
	lrc_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_empty         (q_empty),
		.q_head          (q_head),
		.q_pop           (q_pop),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.hit             (hit),
		.clipped_start_x (clipped_start_x),
		.clipped_start_y (clipped_start_y),
		.clipped_end_x   (clipped_end_x),
		.clipped_end_y   (clipped_end_y),
		.entry_side      (entry_side),
		.exit_side       (exit_side)
	);
endmodule
`default_nettype wire
